/* rtl/avc_length_prefix_to_start_code_top_assert.svh */
// assertion macros shared by the checker
`ifndef AVC_LENGTH_PREFIX_TO_START_CODE_TOP_ASSERT_SVH
`define AVC_LENGTH_PREFIX_TO_START_CODE_TOP_ASSERT_SVH

// antecedent and consequent in the same cycle
`define AVCLP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define AVCLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/avclp_pkg.sv */
package avclp_pkg;

    // chunk kind, one-hot
    typedef enum logic [2:0] {
        MODE_SKIP   = 3'b001,
        MODE_HEADER = 3'b010,
        MODE_DATA   = 3'b100
    } mode_t;

    // parse phase inside a chunk, one-hot
    typedef enum logic [3:0] {
        PH_PRE   = 4'b0001,
        PH_START = 4'b0010,
        PH_LEN   = 4'b0100,
        PH_PAY   = 4'b1000
    } phase_t;

    // result handed from the parser to the output buffer
    typedef struct packed {
        logic       load;
        logic       start_code;
        logic [7:0] data;
    } res_t;

    localparam int DATA_MIN_LEN    = 4;
    localparam int HDR_MIN_LEN     = 10;
    localparam int HDR_SIZE_POS    = 8;
    localparam int HDR_SPS_POS     = 9;
    localparam int DATA_PRE_END    = 3;
    localparam int START_CODE_LEN  = 4;

    localparam logic [2:0] LFS_RESET      = 3'd4;
    localparam logic [2:0] LFS_SHORT      = 3'd2;
    localparam logic [2:0] HDR_FIELD_SIZE = 3'd2;
    localparam logic [1:0] NAL_SIZE_MASK  = 2'h3;
    localparam logic [4:0] SPS_COUNT_MASK = 5'h1F;
    localparam logic [8:0] PPS_UNREAD     = 9'h1FF;
    localparam logic [7:0] START_CODE_END = 8'h01;

endpackage

/* rtl/avclp_parser.sv */
module avclp_parser #(
    parameter int CHUNK_LENGTH_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   data_byte,
    input  logic                         first_byte,
    input  logic [CHUNK_LENGTH_BITS-1:0] chunk_length,
    input  logic                         header_enable,
    input  logic                         out_free,
    output avclp_pkg::res_t              res
);
    import avclp_pkg::*;

    localparam int CLB = CHUNK_LENGTH_BITS;

    // input register
    logic           vld_reg;
    logic [7:0]     byte_reg;
    logic           first_reg;
    logic [CLB-1:0] len_reg;
    logic           hen_reg;

    // parse state
    logic [CLB-1:0] pos_reg, pos_next;
    mode_t          mode_reg, mode_next;
    logic [2:0]     lfs_reg, lfs_next;
    phase_t         phase_reg, phase_next;
    logic [31:0]    acc_reg, acc_next;
    logic [2:0]     lbl_reg, lbl_next;
    logic [CLB-1:0] pay_reg, pay_next;
    logic [4:0]     sps_reg, sps_next;
    logic [8:0]     pps_reg, pps_next;

    logic           adv;
    logic [CLB-1:0] pos_inc;
    logic [2:0]     fsz;
    logic [CLB:0]   field_end;
    logic [31:0]    acc_shift;
    logic [2:0]     lbl_dec;
    logic [32:0]    unit_end;
    logic           overrun;
    logic [CLB-1:0] pay_dec;

    assign adv      = vld_reg && out_free;
    assign in_ready = !vld_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg  <= data_byte;
            first_reg <= first_byte;
            len_reg   <= chunk_length;
            hen_reg   <= header_enable;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            mode_reg  <= MODE_SKIP;
            lfs_reg   <= LFS_RESET;
            phase_reg <= PH_PRE;
            acc_reg   <= '0;
            lbl_reg   <= '0;
            pay_reg   <= '0;
            sps_reg   <= '0;
            pps_reg   <= PPS_UNREAD;
        end
        else
        begin
            pos_reg   <= pos_next;
            mode_reg  <= mode_next;
            lfs_reg   <= lfs_next;
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            lbl_reg   <= lbl_next;
            pay_reg   <= pay_next;
            sps_reg   <= sps_next;
            pps_reg   <= pps_next;
        end
    end

    // saturating position
    assign pos_inc   = (pos_reg == '1) ? pos_reg : pos_reg + CLB'(1);
    assign fsz       = (mode_reg == MODE_HEADER) ? HDR_FIELD_SIZE : lfs_reg;
    assign field_end = {1'b0, pos_reg} + (CLB+1)'(fsz);
    assign acc_shift = {acc_reg[23:0], byte_reg};
    assign lbl_dec   = (lbl_reg != 3'd0) ? lbl_reg - 3'd1 : 3'd0;
    assign unit_end  = 33'(pos_reg) + 33'd1 + {1'b0, acc_shift};
    assign overrun   = acc_shift[31] || (unit_end > 33'(len_reg));
    assign pay_dec   = (pay_reg != '0) ? pay_reg - CLB'(1) : '0;

    always_comb
    begin
        pos_next   = pos_reg;
        mode_next  = mode_reg;
        lfs_next   = lfs_reg;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        lbl_next   = lbl_reg;
        pay_next   = pay_reg;
        sps_next   = sps_reg;
        pps_next   = pps_reg;
        res        = '0;

        if (adv)
        begin
            pos_next = pos_inc;
            if (first_reg)
            begin
                // new chunk, even in the middle of one
                pos_next   = CLB'(1);
                phase_next = PH_PRE;
                acc_next   = '0;
                lbl_next   = '0;
                pay_next   = '0;
                if (len_reg < CLB'(DATA_MIN_LEN))
                begin
                    mode_next = MODE_SKIP;
                end
                else if (byte_reg == 8'h00)
                begin
                    mode_next = (len_reg >= CLB'(HDR_MIN_LEN) && hen_reg)
                                ? MODE_HEADER : MODE_SKIP;
                end
                else
                begin
                    mode_next = MODE_DATA;
                    lfs_next  = (lfs_reg == LFS_SHORT) ? LFS_SHORT : LFS_RESET;
                end
            end
            else if (mode_reg != MODE_SKIP && pos_reg < len_reg)
            begin
                unique case (phase_reg)
                    PH_PRE:
                    begin
                        if (mode_reg == MODE_HEADER)
                        begin
                            if (pos_reg == CLB'(HDR_SIZE_POS))
                            begin
                                lfs_next = {1'b0, byte_reg[1:0] & NAL_SIZE_MASK} + 3'd1;
                            end
                            if (pos_reg == CLB'(HDR_SPS_POS))
                            begin
                                sps_next   = byte_reg[4:0] & SPS_COUNT_MASK;
                                pps_next   = PPS_UNREAD;
                                phase_next = PH_START;
                            end
                        end
                        else if (pos_reg == CLB'(DATA_PRE_END))
                        begin
                            phase_next = PH_START;
                        end
                    end
                    PH_START:
                    begin
                        if (field_end > {1'b0, len_reg})
                        begin
                            mode_next = MODE_SKIP;
                        end
                        else if (mode_reg == MODE_HEADER && sps_reg == '0
                                 && pps_reg == PPS_UNREAD)
                        begin
                            // pps count byte
                            if (byte_reg[7])
                            begin
                                mode_next = MODE_SKIP;
                            end
                            else
                            begin
                                pps_next = {1'b0, byte_reg};
                            end
                        end
                        else if (mode_reg == MODE_HEADER && sps_reg == '0
                                 && pps_reg == '0)
                        begin
                            // all parameter sets copied
                            mode_next = MODE_SKIP;
                        end
                        else
                        begin
                            if (mode_reg == MODE_HEADER)
                            begin
                                if (sps_reg != '0)
                                begin
                                    sps_next = sps_reg - 5'd1;
                                end
                                else
                                begin
                                    pps_next = pps_reg - 9'd1;
                                end
                            end
                            acc_next   = {24'd0, byte_reg};
                            lbl_next   = fsz - 3'd1;
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        acc_next = acc_shift;
                        lbl_next = lbl_dec;
                        if (lbl_dec == 3'd0)
                        begin
                            if (overrun)
                            begin
                                mode_next = MODE_SKIP;
                            end
                            else
                            begin
                                res.load       = 1'b1;
                                res.start_code = 1'b1;
                                pay_next       = acc_shift[CLB-1:0];
                                phase_next     = (acc_shift != '0) ? PH_PAY : PH_START;
                            end
                        end
                    end
                    PH_PAY:
                    begin
                        res.load = 1'b1;
                        res.data = byte_reg;
                        pay_next = pay_dec;
                        if (pay_dec == '0)
                        begin
                            phase_next = PH_START;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_START;
                    end
                endcase
            end
        end
    end

endmodule

/* rtl/avclp_out_buf.sv */
module avclp_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  avclp_pkg::res_t res,
    output logic            out_free,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);
    import avclp_pkg::*;

    // results still to send for the buffered item
    logic [2:0] cnt_reg, cnt_next;
    logic       sc_reg;
    logic [7:0] byte_reg;
    logic       fire;

    assign fire     = m_tvalid && m_tready;
    assign out_free = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && m_tready);
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tlast  = (cnt_reg == 3'd1);
    assign m_tdata  = sc_reg ? ((cnt_reg == 3'd1) ? START_CODE_END : 8'h00) : byte_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (res.load)
        begin
            cnt_next = res.start_code ? 3'(START_CODE_LEN) : 3'd1;
        end
        else if (fire)
        begin
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            sc_reg   <= res.start_code;
            byte_reg <= res.data;
        end
    end

endmodule

/* rtl/avc_length_prefix_to_start_code_top.sv */
// Length-prefixed H.264 to start-code converter. Chunk bytes enter one per
// transfer on the s_ side, with the chunk length in s_tdata and the first-byte
// and header-enable flags in s_tuser; header_enable counts only on a chunk's
// first byte. A header chunk (first byte 0, at least 10 bytes, headers on)
// yields every SPS and PPS behind 00 00 00 01; a chunk of 4 or more bytes
// with a nonzero first byte yields its NAL units behind 00 00 00 01. Units
// that overrun the chunk, or whose length is 2^31 or more, end the chunk
// silently. Each output run closes with m_tlast. Rate: one input byte per
// cycle while output is taken; the last length byte of a unit holds the
// input while its start code is sent from a single output buffer one byte
// a cycle, the next byte waiting in the input register. Input reaches the
// output via the input register and the output buffer. No clearing pass.
module avc_length_prefix_to_start_code_top #(
    parameter int CHUNK_LENGTH_BITS = 24
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // data_byte [7:0], chunk_length [CHUNK_LENGTH_BITS+7:8], zero pad above
    input  logic [((CHUNK_LENGTH_BITS+15)/8)*8-1:0] s_tdata,
    // first_byte [0], header_enable [1]
    input  logic [1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // out_byte [7:0]
    output logic [7:0] m_tdata,
    // run_last: final byte of the run caused by one input transfer
    output logic m_tlast
);
    import avclp_pkg::*;

    res_t res;
    logic out_free;

    // parser: input register, chunk state and the per-byte step
    avclp_parser #(
        .CHUNK_LENGTH_BITS(CHUNK_LENGTH_BITS)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .data_byte    (s_tdata[7:0]),
        .first_byte   (s_tuser[0]),
        .chunk_length (s_tdata[CHUNK_LENGTH_BITS+7:8]),
        .header_enable(s_tuser[1]),
        .out_free     (out_free),
        .res          (res)
    );

    // result register: sends a start code or one payload byte
    avclp_out_buf u_out_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .res     (res),
        .out_free(out_free),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

/* rtl/avclp_checker.sv */
`include "avc_length_prefix_to_start_code_top_assert.svh"

module avclp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // stalled output holds
    `AVCLP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output changed")

    // only start-code zeros come before the end of a run
    `AVCLP_ASSERT_NOW(a_mid_zero, m_tvalid && !m_tlast, m_tdata == 8'h00, "non-final byte is not zero")

    // a started start code keeps going
    `AVCLP_ASSERT_NEXT(a_run_cont, m_tvalid && m_tready && !m_tlast, m_tvalid, "start code broken off")

    // input stalls only behind pending output
    `AVCLP_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid, "input stalled with no output pending")

endmodule

bind avc_length_prefix_to_start_code_top avclp_checker u_avclp_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
